@@ design/assert_macros.svh @@
// Assertion macros shared by the beat detector RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ABD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ABD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/abd_pkg.sv @@
// Package for the audio beat detector: widths, register indexes,
// divider request/response types. No dependencies.
`default_nettype none

package abd_pkg;

  localparam int unsigned DIVIDEND_W = 16;
  localparam int unsigned DIVISOR_W  = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED = 3'd6;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/abd_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on abd_pkg (div_req_t / div_rsp_t).
`default_nettype none

module abd_div import abd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] q_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  diff;

  // partial remainder stays below the divisor, so DIVISOR_W bits hold it
  assign rem_sh = {rem_r, q_r[DIVIDEND_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W - 1);
        q_r    <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        q_r <= {q_r[DIVIDEND_W-2:0], ~diff[DIVISOR_W+1]};
        if (!diff[DIVISOR_W+1]) begin
          rem_r <= diff[DIVISOR_W-1:0];
        end else begin
          rem_r <= rem_sh[DIVISOR_W-1:0];
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

@@ design/audio_beat_detector_core.sv @@
// Audio beat detector top level: sequencer, state, config registers.
// Depends on abd_pkg, abd_div and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_peak): one 8-bit peak level per
//    audio frame. in_ready is high only while the sequencer is idle.
//  - Result channel (out_valid/out_ready/out_beat/out_slow_level): one
//    transaction per input transaction, beat flag plus updated slow average.
//  - Config port (cfg_we/cfg_index/cfg_wdata): single-cycle writes, index
//    0..6 as backoff, slow/fast thresholds, timer max/min, slow/fast speed.
//    Index 7 is ignored. Write only while the block is idle.
//  - Paths: the divisions are skipped while the refractory timer is still at
//    or below its minimum; the long path runs all four divisions (fast ratio,
//    slow ratio, two curvature quotients). Each division occupies the shared
//    bit-serial divider, which sets the throughput; the two IIR updates
//    share one 8x8 multiplier.
//  - One item in flight at a time; the result sits in an output register,
//    so a stalled receiver holds only the final handoff, and the sequencer
//    waits there until the register frees up.
//  - Reset (synchronous, rst_n low): config returns to defaults, timer,
//    averages and peak history clear, no result pending.
`default_nettype none
`include "assert_macros.svh"

module audio_beat_detector_core import abd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_peak,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_beat,
  output logic [7:0]                 out_slow_level,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_FAST, S_SLOW, S_CUR, S_OLD,
    S_MS0, S_MS1, S_MF0, S_MF1, S_DONE
  } state_t;

  state_t state_r;

  // config
  logic [7:0] backoff_r, slow_thr_r, fast_thr_r, tmax_r, slow_spd_r, fast_spd_r;
  logic [6:0] tmin_r;

  // detector state
  logic [7:0] timer_r, slow_avg_r, fast_avg_r, prev_r, pprev_r;

  // per-item work registers
  logic [7:0]            peak_r;
  logic                  beat_r;
  logic                  launched_r;
  logic [DIVIDEND_W-1:0] cur_q_r;
  logic [15:0]           acc_r;

  logic       out_valid_r, out_beat_r;
  logic [7:0] out_level_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [7:0]  timer_inc;
  logic [7:0]  mul_x, mul_y;
  logic [15:0] prod;
  logic [16:0] sum;
  logic        ratio_hit;

  abd_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign timer_inc = (timer_r <= tmax_r) ? timer_r + 8'd1 : timer_r;

  // divider operands per state
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      S_FAST: begin
        div_req.start    = !launched_r && (fast_avg_r != 8'd0);
        div_req.dividend = {1'b0, peak_r, 7'd0};
        div_req.divisor  = {1'b0, fast_avg_r};
      end
      S_SLOW: begin
        div_req.start    = !launched_r && (slow_avg_r != 8'd0);
        div_req.dividend = {1'b0, peak_r, 7'd0};
        div_req.divisor  = {1'b0, slow_avg_r};
      end
      S_CUR: begin
        div_req.start    = !launched_r;
        div_req.dividend = {peak_r, 8'd0};
        div_req.divisor  = {1'b0, prev_r} + 9'd1;
      end
      S_OLD: begin
        div_req.start    = !launched_r;
        div_req.dividend = {prev_r, 8'd0};
        div_req.divisor  = {1'b0, pprev_r} + 9'd1;
      end
      default: begin
      end
    endcase
  end

  // shared multiplier for the IIR: p*s, then a*(255-s) plus the held term
  always_comb begin
    unique case (state_r)
      S_MS0:   begin mul_x = peak_r;     mul_y = slow_spd_r;         end
      S_MS1:   begin mul_x = slow_avg_r; mul_y = 8'd255 - slow_spd_r; end
      S_MF0:   begin mul_x = peak_r;     mul_y = fast_spd_r;         end
      S_MF1:   begin mul_x = fast_avg_r; mul_y = 8'd255 - fast_spd_r; end
      default: begin mul_x = 8'd0;       mul_y = 8'd0;               end
    endcase
  end

  assign prod = mul_x * mul_y;
  assign sum  = {1'b0, acc_r} + {1'b0, prod};

  assign ratio_hit = (state_r == S_FAST) ?
                     (div_rsp.quotient > {8'd0, fast_thr_r}) :
                     (div_rsp.quotient > {8'd0, slow_thr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      beat_r      <= 1'b0;
      timer_r     <= 8'd0;
      slow_avg_r  <= 8'd0;
      fast_avg_r  <= 8'd0;
      prev_r      <= 8'd0;
      pprev_r     <= 8'd0;
      backoff_r   <= 8'd5;
      slow_thr_r  <= 8'd189;
      fast_thr_r  <= 8'd170;
      tmax_r      <= 8'd83;
      tmin_r      <= 7'd5;
      slow_spd_r  <= 8'd89;
      fast_spd_r  <= 8'd169;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BACKOFF:    backoff_r  <= cfg_wdata;
          CFG_SLOW_THR:   slow_thr_r <= cfg_wdata;
          CFG_FAST_THR:   fast_thr_r <= cfg_wdata;
          CFG_TIMER_MAX:  tmax_r     <= cfg_wdata;
          CFG_TIMER_MIN:  tmin_r     <= cfg_wdata[6:0];
          CFG_SLOW_SPEED: slow_spd_r <= cfg_wdata;
          CFG_FAST_SPEED: fast_spd_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // S_DONE reloads the register itself when it hands off
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            peak_r  <= in_peak;
            beat_r  <= 1'b0;
            timer_r <= timer_inc;
            state_r <= (timer_inc > {1'b0, tmin_r}) ? S_FAST : S_MS0;
          end
        end
        S_FAST, S_SLOW: begin
          // zero average saturates the ratio: counts as a hit
          if (((state_r == S_FAST) ? fast_avg_r : slow_avg_r) == 8'd0) begin
            state_r <= S_CUR;
          end else if (div_req.start) begin
            launched_r <= 1'b1;
          end else if (div_rsp.done) begin
            launched_r <= 1'b0;
            if (ratio_hit) begin
              state_r <= S_CUR;
            end else begin
              state_r <= (state_r == S_FAST) ? S_SLOW : S_MS0;
            end
          end
        end
        S_CUR: begin
          if (div_req.start) begin
            launched_r <= 1'b1;
          end else if (div_rsp.done) begin
            launched_r <= 1'b0;
            cur_q_r    <= div_rsp.quotient;
            state_r    <= S_OLD;
          end
        end
        S_OLD: begin
          if (div_req.start) begin
            launched_r <= 1'b1;
          end else if (div_rsp.done) begin
            launched_r <= 1'b0;
            state_r    <= S_MS0;
            // curvature test passed: beat, back the timer off (floor at 0)
            if (cur_q_r > div_rsp.quotient) begin
              beat_r  <= 1'b1;
              timer_r <= (timer_r >= backoff_r) ? timer_r - backoff_r : 8'd0;
            end
          end
        end
        S_MS0: begin
          acc_r   <= prod;
          state_r <= S_MS1;
        end
        S_MS1: begin
          slow_avg_r <= sum[15:8];
          state_r    <= S_MF0;
        end
        S_MF0: begin
          acc_r   <= prod;
          state_r <= S_MF1;
        end
        S_MF1: begin
          fast_avg_r <= sum[15:8];
          pprev_r    <= prev_r;
          prev_r     <= peak_r;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_beat_r  <= beat_r;
            out_level_r <= slow_avg_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_beat       = out_beat_r;
  assign out_slow_level = out_level_r;

  // one item at a time: an accepted transaction blocks the next cycle
  `ABD_ASSERT_NXT(a_accept_blocks, in_valid && in_ready, !in_ready,
    "input accepted while previous item still in flight")
  // the divider is busy, with no completion, right after a launch
  `ABD_ASSERT_NXT(a_div_latency, div_req.start, !div_rsp.done && div_rsp.busy,
    "divider completed too early")
  // quotients only arrive while a division state waits for them
  `ABD_ASSERT_IMP(a_div_owner, div_rsp.done,
    (state_r == S_FAST) || (state_r == S_SLOW) || (state_r == S_CUR) ||
    (state_r == S_OLD),
    "divider result with no consumer")

endmodule

`default_nettype wire

@@ sim/tb_audio_beat_detector_core.sv @@
// Self-checking testbench for audio_beat_detector_core: peak levels in, beat flag and
// slow level out, checked against a cycle-free predictor held in a small scoreboard class.
// Depends on abd_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_audio_beat_detector_core;
  import abd_pkg::*;

  // Index 7 decodes to no register; writes there must leave everything alone.
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  localparam int unsigned ITEMS_PER_PHASE = 420;
  localparam int unsigned LONG_HOLD       = 500;   // receiver back-pressure stretch
  localparam int unsigned STALL_LIMIT     = 3000;  // cycles with no transaction at all
  localparam int unsigned DRAIN_CYCLES    = 100;   // a bit more than worst-case latency

  // Directed frames. The opening six zeros walk the timer past its minimum while both
  // averages are still zero, so the next loud frame hits the saturated-ratio path.
  localparam logic [7:0] OPENING [14] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
                                          8'd255, 8'd0, 8'd0, 8'd40, 8'd200, 8'd1, 8'd128};
  // Run with backoff at or above any timer value and an unbounded timer.
  localparam logic [7:0] WRAPUP [8] = '{8'd0, 8'd255, 8'd3, 8'd255, 8'd0, 8'd254,
                                        8'd255, 8'd17};

  typedef struct packed {
    logic       beat;
    logic [7:0] slow_level;
  } frame_t;

  // Scoreboard: mirrors the detector state, predicts one frame_t per accepted peak and
  // checks results in order.
  class beat_tracker;
    logic [7:0] backoff, slow_thr, fast_thr, timer_max, speed_slow, speed_fast;
    logic [6:0] timer_min;
    logic [7:0] timer, slow_avg, fast_avg, last_peak, older_peak;
    frame_t     expected_frames[$];
    int unsigned mismatches;
    int unsigned frames_seen;

    function new();
      backoff    = 8'd5;
      slow_thr   = 8'd189;
      fast_thr   = 8'd170;
      timer_max  = 8'd83;
      timer_min  = 7'd5;
      speed_slow = 8'd89;
      speed_fast = 8'd169;
      timer      = '0;
      slow_avg   = '0;
      fast_avg   = '0;
      last_peak  = '0;
      older_peak = '0;
      mismatches = 0;
      frames_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BACKOFF:    backoff    = data;
        CFG_SLOW_THR:   slow_thr   = data;
        CFG_FAST_THR:   fast_thr   = data;
        CFG_TIMER_MAX:  timer_max  = data;
        CFG_TIMER_MIN:  timer_min  = data[6:0];
        CFG_SLOW_SPEED: speed_slow = data;
        CFG_FAST_SPEED: speed_fast = data;
        default: ;
      endcase
    endfunction

    // A zero average saturates the ratio, which always counts as over threshold.
    function bit ratio_over(int unsigned scaled, logic [7:0] avg, logic [7:0] thr);
      if (avg == 8'd0) return 1'b1;
      return (scaled / avg) > thr;
    endfunction

    function logic [7:0] smooth(logic [7:0] avg, logic [7:0] p, logic [7:0] spd);
      int unsigned sum;
      sum = p * spd + avg * (8'd255 - spd);
      return 8'(sum >> 8);
    endfunction

    function void note_peak(logic [7:0] p);
      frame_t      f;
      int unsigned scaled, rise_now, rise_then;
      scaled = int'(p) << 7;
      f.beat = 1'b0;
      if (timer <= timer_max) timer = timer + 8'd1;  // wraps 255 -> 0
      if (timer > timer_min &&
          (ratio_over(scaled, fast_avg, fast_thr) || ratio_over(scaled, slow_avg, slow_thr)))
      begin
        // curvature: the jump into this frame must beat the previous jump
        rise_now  = (int'(p) << 8) / (int'(last_peak) + 1);
        rise_then = (int'(last_peak) << 8) / (int'(older_peak) + 1);
        if (rise_now > rise_then) begin
          f.beat = 1'b1;
          timer  = (timer >= backoff) ? timer - backoff : 8'd0;
        end
      end
      slow_avg     = smooth(slow_avg, p, speed_slow);
      fast_avg     = smooth(fast_avg, p, speed_fast);
      older_peak   = last_peak;
      last_peak    = p;
      f.slow_level = slow_avg;
      expected_frames.push_back(f);
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("%0t ns frame %0d: %s got %0d want %0d", $time, frames_seen, what, got, want);
      mismatches++;
    endtask

    task check_frame(logic beat, logic [7:0] level);
      frame_t f;
      if (expected_frames.size() == 0) begin
        report("result with nothing outstanding, beat", beat, 0);
      end else begin
        f = expected_frames.pop_front();
        if (beat !== f.beat) report("beat", beat, f.beat);
        if (level !== f.slow_level) report("slow_level", level, f.slow_level);
      end
      frames_seen++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_peak = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_beat;
  logic [7:0]            out_slow_level;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  beat_tracker frames = new();

  int unsigned sender_idle_pct = 0;   // chance per cycle that the sender sits out
  int unsigned recv_stall_pct  = 0;   // chance per cycle that out_ready is low
  int unsigned hold_requests   = 0;   // bumped by the stimulus to ask for a long hold
  int unsigned hold_served     = 0;
  int unsigned hold_left       = 0;
  int unsigned quiet_cycles    = 0;
  logic [7:0]  peaks[$];              // frames waiting to be offered

  audio_beat_detector_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_peak        (in_peak),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_beat       (out_beat),
    .out_slow_level (out_slow_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus the long hold counted down here. During the hold the
  // sender keeps offering, so the output register fills and in_ready drops.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: every transaction on the result side is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) frames.check_frame(out_beat, out_slow_level);
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // All driving tasks start and end right after a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    frames.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_regs(input logic [7:0] bo, st, ft, tmax, tmin, ss, fs);
    write_reg(CFG_BACKOFF, bo);
    write_reg(CFG_SLOW_THR, st);
    write_reg(CFG_FAST_THR, ft);
    write_reg(CFG_TIMER_MAX, tmax);
    write_reg(CFG_TIMER_MIN, tmin);
    write_reg(CFG_SLOW_SPEED, ss);
    write_reg(CFG_FAST_SPEED, fs);
  endtask

  // Offer one peak; valid stays high across back-to-back transactions.
  task automatic send_peak(input logic [7:0] p);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_peak  = p;
    do @(posedge clk); while (!in_ready);
    frames.note_peak(p);
    @(negedge clk);
  endtask

  // Block must be idle before registers change: every prediction has been matched.
  task automatic drain();
    in_valid = 1'b0;
    while (frames.pending() != 0) @(negedge clk);
  endtask

  // Mostly musical shapes (quiet bed, rising hit, decay) so the ratio and curvature
  // tests both get exercised; the rest is noise, silence and loud runs without a bed.
  task automatic queue_pattern();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  top;
    kind = $urandom_range(9);
    if (kind <= 5) begin
      n = $urandom_range(2, 14);
      repeat (n) peaks.push_back(8'($urandom_range(0, 40)));
      top = 8'($urandom_range(64, 255));
      if ($urandom_range(1)) peaks.push_back(top >> 1);
      peaks.push_back(top);
      n = $urandom_range(1, 5);
      repeat (n) begin
        top = top >> 1;
        peaks.push_back(top);
      end
    end else if (kind <= 7) begin
      n = $urandom_range(1, 8);
      repeat (n) peaks.push_back(8'($urandom));
    end else if (kind == 8) begin
      // long silence pulls the averages to zero -> saturated ratios
      n = $urandom_range(4, 40);
      repeat (n) peaks.push_back(8'd0);
    end else begin
      n = $urandom_range(2, 10);
      repeat (n) peaks.push_back(8'($urandom_range(128, 255)));
    end
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    peaks.delete();
    repeat (count) begin
      if (peaks.size() == 0) queue_pattern();
      send_peak(peaks.pop_front());
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset defaults, extremes of the peak, zero-average saturation.
    foreach (OPENING[i]) send_peak(OPENING[i]);
    drain();

    // Directed: unused index is ignored, timer_minimum drops bit 7 (0x80 -> 0),
    // backoff larger than the timer clamps it to zero, timer runs to 255.
    write_reg(CFG_NONE, 8'hFF);
    write_reg(CFG_TIMER_MIN, 8'h80);
    write_reg(CFG_BACKOFF, 8'd255);
    write_reg(CFG_TIMER_MAX, 8'd255);
    foreach (WRAPUP[i]) send_peak(WRAPUP[i]);
    drain();

    // Zero thresholds, zero backoff, unbounded timer (wraps 255 -> 0), full-speed
    // averages. No idling, and a long receiver hold to fill the pipe and stall input.
    program_regs(8'd0, 8'd0, 8'd0, 8'd255, 8'd3, 8'd255, 8'd255);
    hold_requests++;
    run_phase(ITEMS_PER_PHASE, 0, 0);

    // Max thresholds and backoff, timer pinned at one, frozen (decaying) averages.
    program_regs(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    run_phase(ITEMS_PER_PHASE, 73, 0);

    // Reset values written back explicitly.
    program_regs(8'd5, 8'd189, 8'd170, 8'd83, 8'd5, 8'd89, 8'd169);
    run_phase(ITEMS_PER_PHASE, 0, 73);

    // Largest legal timer maximum with the largest minimum.
    program_regs(8'd20, 8'd140, 8'd120, 8'd254, 8'd127, 8'd30, 8'd200);
    run_phase(ITEMS_PER_PHASE, 26, 26);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frames.mismatches == 0 && frames.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
